>>> src/line_message_tokenizer_defines.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef LINE_MESSAGE_TOKENIZER_DEFINES_SVH
`define LINE_MESSAGE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, checked out of reset
`define LMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

>>> src/lmt_pkg.sv
`default_nettype none

package lmt_pkg;

    // prefix storage limit, in characters
    localparam int MAX_PREFIX = 8;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_PREFIX_BYTES = 2'd0;
    localparam logic [1:0] CFG_PREFIX_COUNT = 2'd1;

    // characters with a special meaning
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // message kinds
    localparam logic [2:0] KIND_NONE = 3'd7;
    localparam logic [2:0] KIND_MAX  = 3'd4;

    typedef enum logic [2:0] {
        EV_TOK      = 3'd0,
        EV_VAL      = 3'd1,
        EV_ARG_END  = 3'd2,
        EV_KEY_END  = 3'd3,
        EV_PAIR_END = 3'd4,
        EV_START    = 3'd5,
        EV_END      = 3'd6,
        EV_ABORT    = 3'd7
    } t_event;

    typedef enum logic [12:0] {
        ST_PREFIX      = 13'b0_0000_0000_0001,
        ST_TYPE        = 13'b0_0000_0000_0010,
        ST_PASS        = 13'b0_0000_0000_0100,
        ST_SPACE_EXPCT = 13'b0_0000_0000_1000,
        ST_SPACE       = 13'b0_0000_0001_0000,
        ST_UKEY        = 13'b0_0000_0010_0000,
        ST_UVAL        = 13'b0_0000_0100_0000,
        ST_UKEY_ESC    = 13'b0_0000_1000_0000,
        ST_UVAL_ESC    = 13'b0_0001_0000_0000,
        ST_QKEY        = 13'b0_0010_0000_0000,
        ST_QVAL        = 13'b0_0100_0000_0000,
        ST_QKEY_ESC    = 13'b0_1000_0000_0000,
        ST_QVAL_ESC    = 13'b1_0000_0000_0000
    } t_mode;

    typedef struct packed {
        t_event     ev;
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } t_result;

    // keyword table: hello, initialize, state, status, frame, quit
    localparam int KW_NUM = 6;
    localparam int KW_MAXLEN = 10;

    localparam logic [7:0] KW_TEXT [0:KW_NUM-1][0:KW_MAXLEN-1] = '{
        '{"h", "e", "l", "l", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "i", "t", "i", "a", "l", "i", "z", "e"},
        '{"s", "t", "a", "t", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "a", "t", "u", "s", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "r", "a", "m", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"q", "u", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN  [0:KW_NUM-1] = '{4'd5, 4'd10, 4'd5, 4'd6, 4'd5, 4'd4};
    localparam logic [2:0] KW_KIND [0:KW_NUM-1] = '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4};

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {["0":"9"], ["A":"Z"], ["a":"z"]});
    endfunction

    function automatic logic key_char_ok(input logic [7:0] c);
        return is_alnum(c) || (c == CH_DOT) || (c == CH_USCORE);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {["A":"Z"]}) ? c + CASE_GAP : c;
    endfunction

endpackage

`default_nettype wire

>>> src/line_message_tokenizer.sv
// line_message_tokenizer: streaming tokenizer for newline-ended text messages.
// Input channel (i_valid/o_ready) takes one character a beat in i_in_byte, or
// a stream-closed marker when i_stream_end is set. Output channel
// (o_valid/i_ready) delivers one event a beat; o_last flags the final event
// caused by an input beat. Most beats cause zero or one event; a known keyword
// ended by newline, or an unquoted key or value ended by newline or stream
// end, causes two. Configuration channel (i_cfg_valid/o_cfg_ready) writes the
// prefix text (index 0) and prefix length (index 1); it is always ready. The
// user must write it only while the tokenizer is idle; the block does not
// enforce this. Events are registered into the result queue when their input
// beat is accepted and presented from its head. Throughput: one input beat per
// cycle while o_ready is high. All parsing is done by the decode logic in the
// accept cycle; events land in a four-entry result queue. Input ready drops
// when fewer than two queue slots are free, so a stalled receiver backs the
// input up after at most three beats that cause events, and a two-event beat
// fills two queue slots. Reset: parser returns to prefix matching, the queue
// empties and the prefix registers clear (empty prefix).
`default_nettype none
`include "line_message_tokenizer_defines.svh"

module line_message_tokenizer
    import lmt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input characters
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_stream_end,
    // events
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_msg_kind,
    output logic             o_last,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    // configuration
    logic [63:0] r_prefix_bytes;
    logic [3:0]  r_prefix_count;

    // parser state
    t_mode       r_mode,     n_mode;
    logic [3:0]  r_pidx,     n_pidx;
    logic [5:0]  r_cand,     n_cand;
    logic [3:0]  r_klen,     n_klen;
    logic [2:0]  r_open,     n_open;
    logic        r_key_ok,   n_key_ok;

    // result queue
    t_result          r_q [0:Q_DEPTH-1];
    logic [Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]    r_count,  n_count;

    // decode signals
    logic            in_acc, out_acc;
    logic [3:0]      cnt_eff;
    logic [7:0]      c, lc, esc_c, pb;
    logic            do_type;
    logic [5:0]      t_cand;
    logic [3:0]      t_klen;
    logic [2:0]      hit_kind;
    logic [1:0]      res_cnt;
    t_result         res0, res1;

    assign in_acc      = i_valid && o_ready;
    assign out_acc     = o_valid && i_ready;
    assign o_cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bytes <= '0;
            r_prefix_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PREFIX_BYTES: r_prefix_bytes <= i_cfg_data;
                CFG_PREFIX_COUNT: r_prefix_count <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective prefix length and current prefix character
    assign cnt_eff = (r_prefix_count > 4'(MAX_PREFIX)) ? 4'(MAX_PREFIX) : r_prefix_count;
    assign pb      = r_prefix_bytes[8*r_pidx[2:0] +: 8];
    assign c       = i_in_byte;
    assign lc      = to_lower(c);
    assign esc_c   = (c == CH_LOW_N) ? CH_NL : c;

    // keyword tracking restarts when the keyword begins in this beat
    assign t_cand = (r_mode == ST_PREFIX) ? 6'h3F : r_cand;
    assign t_klen = (r_mode == ST_PREFIX) ? 4'd0  : r_klen;

    // first full keyword match, table order
    always_comb begin
        hit_kind = KIND_NONE;
        for (int i = KW_NUM - 1; i >= 0; i--) begin
            if (t_cand[i] && (KW_LEN[i] == t_klen)) begin
                hit_kind = KW_KIND[i];
            end
        end
    end

    // parser next state and events for one beat
    always_comb begin
        n_mode   = r_mode;
        n_pidx   = r_pidx;
        n_cand   = r_cand;
        n_klen   = r_klen;
        n_open   = r_open;
        n_key_ok = r_key_ok;
        do_type  = 1'b0;
        res_cnt  = 2'd0;
        res0     = '{ev: EV_TOK, data: 8'h00, kind: 3'd0, last: 1'b0};
        res1     = '{ev: EV_TOK, data: 8'h00, kind: 3'd0, last: 1'b1};

        if (i_stream_end) begin
            // stream closed: end or abort whatever message is open
            if (r_open != KIND_NONE) begin
                case (r_mode)
                    ST_UKEY: begin
                        res_cnt = 2'd2;
                        res0.ev = EV_ARG_END;
                        res1.ev = EV_END;
                    end
                    ST_UVAL: begin
                        res_cnt = 2'd2;
                        res0.ev = EV_PAIR_END;
                        res1.ev = EV_END;
                    end
                    ST_UKEY_ESC, ST_UVAL_ESC, ST_QKEY_ESC, ST_QVAL_ESC: begin
                        res_cnt = 2'd1;
                        res0.ev = EV_ABORT;
                    end
                    default: begin
                        res_cnt = 2'd1;
                        res0.ev = EV_END;
                    end
                endcase
            end
            n_mode = ST_PREFIX;
            n_pidx = 4'd0;
            n_open = KIND_NONE;
        end else begin
            case (r_mode)
                ST_PREFIX: begin
                    if (r_pidx < cnt_eff) begin
                        if (c == pb) begin
                            n_pidx = r_pidx + 4'd1;
                            if (r_pidx + 4'd1 >= cnt_eff) begin
                                n_mode = ST_TYPE;
                                n_cand = 6'h3F;
                                n_klen = 4'd0;
                            end
                        end else if (c == CH_NL) begin
                            n_pidx = 4'd0;
                            n_open = KIND_NONE;
                        end else begin
                            n_mode = ST_PASS;
                        end
                    end else begin
                        do_type = 1'b1;
                    end
                end
                ST_TYPE: do_type = 1'b1;
                ST_PASS: begin
                    if (c == CH_NL) begin
                        n_mode = ST_PREFIX;
                        n_pidx = 4'd0;
                        n_open = KIND_NONE;
                    end
                end
                ST_SPACE_EXPCT: begin
                    if (c == CH_SPACE) begin
                        n_mode = ST_SPACE;
                    end else if (c == CH_NL) begin
                        res_cnt = 2'd1;
                        res0.ev = EV_END;
                        n_mode  = ST_PREFIX;
                        n_pidx  = 4'd0;
                        n_open  = KIND_NONE;
                    end else begin
                        res_cnt = 2'd1;
                        res0.ev = EV_ABORT;
                        n_mode  = ST_PASS;
                        n_open  = KIND_NONE;
                    end
                end
                ST_SPACE: begin
                    if (c == CH_SPACE || c == CH_CR) begin
                        n_mode = ST_SPACE;
                    end else if (c == CH_NL) begin
                        res_cnt = 2'd1;
                        res0.ev = EV_END;
                        n_mode  = ST_PREFIX;
                        n_pidx  = 4'd0;
                        n_open  = KIND_NONE;
                    end else if (c == CH_QUOTE) begin
                        n_mode   = ST_QKEY;
                        n_key_ok = 1'b1;
                    end else begin
                        // first byte of an unquoted token is always literal
                        n_mode    = ST_UKEY;
                        n_key_ok  = key_char_ok(c);
                        res_cnt   = 2'd1;
                        res0.ev   = EV_TOK;
                        res0.data = c;
                    end
                end
                ST_UKEY, ST_QKEY: begin
                    if (c == CH_BSLASH) begin
                        n_mode = (r_mode == ST_UKEY) ? ST_UKEY_ESC : ST_QKEY_ESC;
                    end else if (c == CH_EQ) begin
                        res_cnt = 2'd1;
                        if (r_key_ok) begin
                            res0.ev = EV_KEY_END;
                            n_mode  = (r_mode == ST_UKEY) ? ST_UVAL : ST_QVAL;
                        end else begin
                            res0.ev = EV_ABORT;
                            n_mode  = ST_PASS;
                            n_open  = KIND_NONE;
                        end
                    end else if (r_mode == ST_QKEY && c == CH_QUOTE) begin
                        res_cnt = 2'd1;
                        res0.ev = EV_ARG_END;
                        n_mode  = ST_SPACE_EXPCT;
                    end else if (r_mode == ST_UKEY && c == CH_SPACE) begin
                        res_cnt = 2'd1;
                        res0.ev = EV_ARG_END;
                        n_mode  = ST_SPACE;
                    end else if (r_mode == ST_UKEY && c == CH_NL) begin
                        res_cnt = 2'd2;
                        res0.ev = EV_ARG_END;
                        res1.ev = EV_END;
                        n_mode  = ST_PREFIX;
                        n_pidx  = 4'd0;
                        n_open  = KIND_NONE;
                    end else begin
                        n_key_ok  = r_key_ok & key_char_ok(c);
                        res_cnt   = 2'd1;
                        res0.ev   = EV_TOK;
                        res0.data = c;
                    end
                end
                ST_UVAL: begin
                    if (c == CH_BSLASH) begin
                        n_mode = ST_UVAL_ESC;
                    end else if (c == CH_SPACE) begin
                        res_cnt = 2'd1;
                        res0.ev = EV_PAIR_END;
                        n_mode  = ST_SPACE;
                    end else if (c == CH_NL) begin
                        res_cnt = 2'd2;
                        res0.ev = EV_PAIR_END;
                        res1.ev = EV_END;
                        n_mode  = ST_PREFIX;
                        n_pidx  = 4'd0;
                        n_open  = KIND_NONE;
                    end else begin
                        res_cnt   = 2'd1;
                        res0.ev   = EV_VAL;
                        res0.data = c;
                    end
                end
                ST_QVAL: begin
                    if (c == CH_BSLASH) begin
                        n_mode = ST_QVAL_ESC;
                    end else if (c == CH_QUOTE) begin
                        res_cnt = 2'd1;
                        res0.ev = EV_PAIR_END;
                        n_mode  = ST_SPACE_EXPCT;
                    end else begin
                        res_cnt   = 2'd1;
                        res0.ev   = EV_VAL;
                        res0.data = c;
                    end
                end
                ST_UKEY_ESC, ST_QKEY_ESC: begin
                    res_cnt = 2'd1;
                    if (c == CH_NL) begin
                        res0.ev = EV_ABORT;
                        n_mode  = ST_PASS;
                        n_open  = KIND_NONE;
                    end else begin
                        n_key_ok  = r_key_ok & key_char_ok(esc_c);
                        res0.ev   = EV_TOK;
                        res0.data = esc_c;
                        n_mode    = (r_mode == ST_UKEY_ESC) ? ST_UKEY : ST_QKEY;
                    end
                end
                ST_UVAL_ESC, ST_QVAL_ESC: begin
                    res_cnt = 2'd1;
                    if (c == CH_NL) begin
                        res0.ev = EV_ABORT;
                        n_mode  = ST_PASS;
                        n_open  = KIND_NONE;
                    end else begin
                        res0.ev   = EV_VAL;
                        res0.data = esc_c;
                        n_mode    = (r_mode == ST_UVAL_ESC) ? ST_UVAL : ST_QVAL;
                    end
                end
                default: begin
                    n_mode = ST_PREFIX;
                    n_pidx = 4'd0;
                    n_open = KIND_NONE;
                end
            endcase

            // keyword character or keyword terminator
            if (do_type) begin
                n_mode = ST_TYPE;
                n_cand = t_cand;
                n_klen = t_klen;
                if (is_alnum(c)) begin
                    for (int i = 0; i < KW_NUM; i++) begin
                        if (t_klen >= KW_LEN[i]) begin
                            n_cand[i] = 1'b0;
                        end else if (KW_TEXT[i][t_klen] != lc) begin
                            n_cand[i] = 1'b0;
                        end
                    end
                    if (t_klen != 4'hF) begin
                        n_klen = t_klen + 4'd1;
                    end
                end else if (c != CH_SPACE && c != CH_NL) begin
                    n_mode = ST_PASS;
                end else if (hit_kind == KIND_NONE) begin
                    if (c == CH_SPACE) begin
                        n_mode = ST_PASS;
                    end else begin
                        n_mode = ST_PREFIX;
                        n_pidx = 4'd0;
                        n_open = KIND_NONE;
                    end
                end else begin
                    res0.ev   = EV_START;
                    res0.kind = hit_kind;
                    if (c == CH_SPACE) begin
                        res_cnt = 2'd1;
                        n_mode  = ST_SPACE;
                        n_open  = hit_kind;
                    end else begin
                        res_cnt = 2'd2;
                        res1.ev = EV_END;
                        n_mode  = ST_PREFIX;
                        n_pidx  = 4'd0;
                        n_open  = KIND_NONE;
                    end
                end
            end
        end

        res0.last = (res_cnt == 2'd1);
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_PREFIX;
            r_pidx   <= 4'd0;
            r_cand   <= 6'h3F;
            r_klen   <= 4'd0;
            r_open   <= KIND_NONE;
            r_key_ok <= 1'b1;
        end else if (in_acc) begin
            r_mode   <= n_mode;
            r_pidx   <= n_pidx;
            r_cand   <= n_cand;
            r_klen   <= n_klen;
            r_open   <= n_open;
            r_key_ok <= n_key_ok;
        end
    end

    // result queue: up to two pushes per beat, one pop
    always_comb begin
        n_count = r_count - {{Q_AW{1'b0}}, out_acc};
        if (in_acc) begin
            n_count = n_count + {{(Q_AW-1){1'b0}}, res_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(res_cnt);
            end
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && res_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (in_acc && res_cnt == 2'd2) begin
            r_q[r_wr_ptr + Q_AW'(1)] <= res1;
        end
    end

    // handshakes and output fields
    assign o_ready     = (r_count <= (Q_AW+1)'(Q_DEPTH - 2));
    assign o_valid     = (r_count != '0);
    assign o_event_res = r_q[r_rd_ptr].ev;
    assign o_out_byte  = r_q[r_rd_ptr].data;
    assign o_msg_kind  = r_q[r_rd_ptr].kind;
    assign o_last      = r_q[r_rd_ptr].last;

    // checks
    `LMT_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= (Q_AW+1)'(Q_DEPTH))
    `LMT_ASSERT_NOW(a_pair_last, i_clk, i_rst_n, in_acc && res_cnt == 2'd2, !res0.last && res1.last)
    `LMT_ASSERT_NOW(a_prefix_closed, i_clk, i_rst_n, r_mode == ST_PREFIX, r_open == KIND_NONE)
    `LMT_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, in_acc && res_cnt != 2'd0, o_valid)
    `LMT_ASSERT_NOW(a_start_kind, i_clk, i_rst_n, o_valid && o_event_res == EV_START, o_msg_kind <= KIND_MAX)

endmodule

`default_nettype wire
